// ===== rtl/dzg_pkg.sv =====
// Package for the temporal outlier dezinger: register indexes, output modes,
// arithmetic constants and the side-band record carried down the score pipeline.
// No dependencies.
package dzg_pkg;

  // Configuration register indexes.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MODE      = 1'b1;

  // Output mode codes.
  localparam logic [1:0] MODE_CORRECT = 2'd0;
  localparam logic [1:0] MODE_SCORE   = 2'd1;
  localparam logic [1:0] MODE_FLAG    = 2'd2;

  // Reset values and constants.
  localparam logic [15:0] THRESHOLD_RESET = 16'd768;
  localparam logic [19:0] SCORE_SCALE     = 20'd750000;
  localparam logic [15:0] FLAG_VALUE      = 16'd50000;
  localparam logic [15:0] SCORE_MAX       = 16'hFFFF;

  // Pipeline geometry of the score path.
  localparam int DivSteps  = 32;
  localparam int SqrtSteps = 16;

  // Per-item decisions and pass-through values that ride along the score path.
  typedef struct packed {
    logic        over;   // test value exceeds the threshold
    logic        dz;     // center equals the neighbor mean exactly
    logic        vz;     // neighbors have zero deviation
    logic        sat;    // score quotient does not fit in 32 bits
    logic [15:0] mean;
    logic [15:0] center;
  } side_t;

endpackage

// ===== rtl/temporal_outlier_dezinger_core.sv =====
// Temporal outlier dezinger, top level: front arithmetic stages, score pipeline
// and output register. Depends on dzg_pkg and dzg_score_pipe.
//
// The core takes one five-frame pixel window per clock while it is not stalled
// and returns one pixel per window, in order. Each window passes through six
// stages of sums, squares and partial products, 32 divider stages and 16
// square-root stages, then the output register; all modes share that path. A held
// result stalls the whole pipeline in lockstep, so in_ready follows
// out_ready whenever a result is waiting. Configuration must be written only
// while the pipeline is empty.
module temporal_outlier_dezinger_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_sample_prev2,
  input  logic [15:0] in_sample_prev1,
  input  logic [15:0] in_center_sample,
  input  logic [15:0] in_sample_next1,
  input  logic [15:0] in_sample_next2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_out,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import dzg_pkg::*;

  logic        en;
  logic [15:0] thr_r;
  logic [1:0]  mode_r;
  logic [31:0] t2_r;

  // Stage registers.
  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [17:0] s1_s_r;
  logic [32:0] s1_qa_r, s1_qb_r;
  logic [15:0] s1_c_r;
  logic [33:0] s2_q_r;
  logic [35:0] s2_ss_r;
  logic [17:0] s2_d_r;
  logic [15:0] s2_mean_r, s2_c_r;
  logic [33:0] s3_v_r;
  logic [35:0] s3_d2_r;
  logic        s3_dz_r;
  logic [15:0] s3_mean_r, s3_c_r;
  logic [51:0] s4_x_r;
  logic [37:0] s4_nhi_r, s4_nlo_r;
  logic [48:0] s4_pvh_r, s4_pvl_r;
  logic [33:0] s4_v_r;
  logic        s4_dz_r, s4_vz_r;
  logic [15:0] s4_mean_r, s4_c_r;
  logic [55:0] s5_num_r;
  logic [65:0] s5_vt_r;
  logic [51:0] s5_x_r;
  logic [33:0] s5_v_r;
  logic        s5_dz_r, s5_vz_r;
  logic [15:0] s5_mean_r, s5_c_r;
  logic [55:0] s6_num_r;
  logic [33:0] s6_v_r;
  side_t       s6_side_r;

  logic        sp_vld;
  logic [15:0] sp_root;
  side_t       sp_side;
  logic        out_valid_r;
  logic [15:0] pixel_r, pixel_nxt;
  logic [17:0] c4;

  // The pipeline advances unless a finished result is being held.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Configuration registers and the squared threshold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RESET;
      mode_r <= MODE_CORRECT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r  <= cfg_wdata;
        REG_MODE:      mode_r <= cfg_wdata[1:0];
        default:       thr_r  <= thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    t2_r <= 32'(thr_r) * 32'(thr_r);
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r} <= '0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign c4 = {s1_c_r, 2'b00};

  // Front datapath: sums and squares, deviation terms, partial products, compares.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_s_r  <= 18'(in_sample_prev2) + 18'(in_sample_prev1)
               + 18'(in_sample_next1) + 18'(in_sample_next2);
      s1_qa_r <= 33'(in_sample_prev2 * in_sample_prev2) + 33'(in_sample_prev1 * in_sample_prev1);
      s1_qb_r <= 33'(in_sample_next1 * in_sample_next1) + 33'(in_sample_next2 * in_sample_next2);
      s1_c_r  <= in_center_sample;

      s2_q_r    <= 34'(s1_qa_r) + 34'(s1_qb_r);
      s2_ss_r   <= 36'(s1_s_r) * 36'(s1_s_r);
      s2_d_r    <= (s1_s_r >= c4) ? (s1_s_r - c4) : (c4 - s1_s_r);
      s2_mean_r <= s1_s_r[17:2];
      s2_c_r    <= s1_c_r;

      s3_v_r    <= 34'({s2_q_r, 2'b00} - s2_ss_r);
      s3_d2_r   <= 36'(s2_d_r) * 36'(s2_d_r);
      s3_dz_r   <= (s2_d_r == '0);
      s3_mean_r <= s2_mean_r;
      s3_c_r    <= s2_c_r;

      s4_x_r    <= 52'({s3_d2_r, 15'd0}) + 52'({s3_d2_r, 14'd0});
      s4_nhi_r  <= 38'(s3_d2_r[35:18]) * 38'(SCORE_SCALE);
      s4_nlo_r  <= 38'(s3_d2_r[17:0]) * 38'(SCORE_SCALE);
      s4_pvh_r  <= 49'(s3_v_r[33:17]) * 49'(t2_r);
      s4_pvl_r  <= 49'(s3_v_r[16:0]) * 49'(t2_r);
      s4_v_r    <= s3_v_r;
      s4_dz_r   <= s3_dz_r;
      s4_vz_r   <= (s3_v_r == '0);
      s4_mean_r <= s3_mean_r;
      s4_c_r    <= s3_c_r;

      s5_num_r  <= 56'({s4_nhi_r, 18'd0}) + 56'(s4_nlo_r);
      s5_vt_r   <= 66'({s4_pvh_r, 17'd0}) + 66'(s4_pvl_r);
      s5_x_r    <= s4_x_r;
      s5_v_r    <= s4_v_r;
      s5_dz_r   <= s4_dz_r;
      s5_vz_r   <= s4_vz_r;
      s5_mean_r <= s4_mean_r;
      s5_c_r    <= s4_c_r;

      s6_num_r         <= s5_num_r;
      s6_v_r           <= s5_v_r;
      s6_side_r.over   <= (66'(s5_x_r) > s5_vt_r);
      s6_side_r.sat    <= (34'(s5_num_r[55:32]) >= s5_v_r);
      s6_side_r.dz     <= s5_dz_r;
      s6_side_r.vz     <= s5_vz_r;
      s6_side_r.mean   <= s5_mean_r;
      s6_side_r.center <= s5_c_r;
    end
  end

  dzg_score_pipe u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v6_r),
    .in_num   (s6_num_r),
    .in_den   (s6_v_r),
    .in_side  (s6_side_r),
    .out_vld  (sp_vld),
    .out_root (sp_root),
    .out_side (sp_side)
  );

  // Result selection by mode.
  always_comb begin
    case (mode_r)
      MODE_SCORE: begin
        if (sp_side.dz) begin
          pixel_nxt = '0;
        end else if (sp_side.vz || sp_side.sat) begin
          pixel_nxt = SCORE_MAX;
        end else begin
          pixel_nxt = sp_root;
        end
      end
      MODE_FLAG: pixel_nxt = sp_side.over ? FLAG_VALUE : '0;
      default:   pixel_nxt = sp_side.over ? sp_side.mean : sp_side.center;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = pixel_r;

endmodule

// ===== rtl/dzg_score_pipe.sv =====
// Score pipeline of the dezinger: a 32-stage restoring divider followed by a
// 16-stage integer square root, one result bit per stage.
// Depends on dzg_pkg.
module dzg_score_pipe (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [55:0]   in_num,
  input  logic [33:0]   in_den,
  input  dzg_pkg::side_t in_side,
  output logic          out_vld,
  output logic [15:0]   out_root,
  output dzg_pkg::side_t out_side
);
  import dzg_pkg::*;

  // Divider stage registers; index 0 is the entry.
  logic [33:0] rem_r  [0:DivSteps];
  logic [31:0] lo_r   [0:DivSteps];
  logic [31:0] quo_r  [0:DivSteps];
  logic [33:0] den_r  [0:DivSteps];
  side_t       dside_r[0:DivSteps];
  logic        dvld_r [0:DivSteps];

  // Square root stage registers; index 0 is fed by the divider.
  logic [31:0] x_r    [0:SqrtSteps];
  logic [31:0] res_r  [0:SqrtSteps];
  side_t       sside_r[0:SqrtSteps];
  logic        svld_r [0:SqrtSteps];

  // Divider entry: upper numerator bits are below the divisor unless sat is set.
  always_comb begin
    rem_r[0]   = {10'd0, in_num[55:32]};
    lo_r[0]    = in_num[31:0];
    quo_r[0]   = '0;
    den_r[0]   = in_den;
    dside_r[0] = in_side;
    dvld_r[0]  = in_vld;
  end

  // One quotient bit per stage.
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [34:0] trial;
    logic        take;
    assign trial = {rem_r[j], lo_r[j][31]};
    assign take  = trial >= {1'b0, den_r[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[j+1] <= 1'b0;
      end else if (en) begin
        dvld_r[j+1] <= dvld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]   <= take ? 34'(trial - {1'b0, den_r[j]}) : trial[33:0];
        lo_r[j+1]    <= {lo_r[j][30:0], 1'b0};
        quo_r[j+1]   <= {quo_r[j][30:0], take};
        den_r[j+1]   <= den_r[j];
        dside_r[j+1] <= dside_r[j];
      end
    end
  end

  // Square root entry takes the quotient.
  always_comb begin
    x_r[0]     = quo_r[DivSteps];
    res_r[0]   = '0;
    sside_r[0] = dside_r[DivSteps];
    svld_r[0]  = dvld_r[DivSteps];
  end

  // One root bit per stage, digit-by-digit with a running remainder.
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [31:0] Bit = 32'(1) << (2 * (SqrtSteps - 1 - k));
    logic [32:0] sum;
    logic        take;
    assign sum  = {1'b0, res_r[k]} + {1'b0, Bit};
    assign take = {1'b0, x_r[k]} >= sum;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svld_r[k+1] <= 1'b0;
      end else if (en) begin
        svld_r[k+1] <= svld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1]     <= take ? 32'(x_r[k] - sum[31:0]) : x_r[k];
        res_r[k+1]   <= take ? ((res_r[k] >> 1) + Bit) : (res_r[k] >> 1);
        sside_r[k+1] <= sside_r[k];
      end
    end
  end

  assign out_vld  = svld_r[SqrtSteps];
  assign out_root = res_r[SqrtSteps][15:0];
  assign out_side = sside_r[SqrtSteps];

endmodule

// ===== rtl/dzg_checker.sv =====
// Port-level checker for the dezinger core and its bind statement.
// Depends on temporal_outlier_dezinger_core.
module dzg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel_out
);

  // A held result keeps its value until the transfer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out))
    else $error("held result changed");

  // Input side is open exactly when the output can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready disagrees with output state");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind temporal_outlier_dezinger_core dzg_checker u_dzg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pixel_out (out_pixel_out)
);
